>>> src/spibte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spibte_pkg
// shared constants, codes and types of the buffered spi transfer engine
// ----------------------------------------------------------------------------
package spibte_pkg;

   localparam int RING_DEPTH = 16;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   // request codes
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_DONE = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BUSY    = 2'd1;
   localparam logic [1:0] STATUS_SIZE    = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   // one access cycle of a byte ring
   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } ring_req_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

>>> src/spi_buffered_transfer_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_buffered_transfer_engine_core
// buffered spi master transfer engine: transmit and receive byte rings
//
//   channel  handshake            payload
//   req_     req_valid/req_ready  req_type, req_tx_data, req_last_load,
//                                 req_rx_data
//   rsp_     rsp_valid/rsp_ready  rsp_status, rsp_shift_valid, rsp_shift_byte,
//                                 rsp_read_valid, rsp_read_byte,
//                                 rsp_transfer_active
//
// each transfer does the pointer update and ring access first, then the
// registered ring read data forms the result; no new item is taken before that;
// a result waits in the output register while the next item is accepted;
// req_ready stays low while a result is formed and until the output register
// is free to take it
// synchronous reset clears pointers, counters and flags; rings undefined until written
// ----------------------------------------------------------------------------
module spi_buffered_transfer_engine_core
   import spibte_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_tx_data,
   input  wire logic       req_last_load,
   input  wire logic [7:0] req_rx_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic            rsp_shift_valid,
   output logic [7:0]      rsp_shift_byte,
   output logic            rsp_read_valid,
   output logic [7:0]      rsp_read_byte,
   output logic            rsp_transfer_active
);

   ring_req_type tx_req, rx_req;
   logic [7:0]   tx_rd_data, rx_rd_data;

   spibte_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_tx_data         (req_tx_data),
      .req_last_load       (req_last_load),
      .req_rx_data         (req_rx_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_shift_valid     (rsp_shift_valid),
      .rsp_shift_byte      (rsp_shift_byte),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_transfer_active (rsp_transfer_active),
      .tx_req              (tx_req),
      .rx_req              (rx_req),
      .tx_rd_data          (tx_rd_data),
      .rx_rd_data          (rx_rd_data)
   );

   spibte_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_tx_ring (
      .clock   (clock),
      .wr_en   (tx_req.wr_en),
      .wr_addr (tx_req.wr_addr),
      .wr_data (tx_req.wr_data),
      .rd_en   (tx_req.rd_en),
      .rd_addr (tx_req.rd_addr),
      .rd_data (tx_rd_data)
   );

   spibte_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_rx_ring (
      .clock   (clock),
      .wr_en   (rx_req.wr_en),
      .wr_addr (rx_req.wr_addr),
      .wr_data (rx_req.wr_data),
      .rd_en   (rx_req.rd_en),
      .rd_addr (rx_req.rd_addr),
      .rd_data (rx_rd_data)
   );

endmodule
`default_nettype wire

>>> src/spibte_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spibte_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module spibte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/spibte_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spibte_ctrl
// ring pointers, transfer state and result register of the transfer engine
// ----------------------------------------------------------------------------
module spibte_ctrl
   import spibte_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_type,
   input  wire logic [7:0]   req_tx_data,
   input  wire logic         req_last_load,
   input  wire logic [7:0]   req_rx_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_status,
   output logic              rsp_shift_valid,
   output logic [7:0]        rsp_shift_byte,
   output logic              rsp_read_valid,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_transfer_active,
   output ring_req_type      tx_req,
   output ring_req_type      rx_req,
   input  wire logic [7:0]   tx_rd_data,
   input  wire logic [7:0]   rx_rd_data
);

   typedef enum logic {S_IDLE, S_RESULT} state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [CNT_W-1:0] bytes_left_ff, bytes_left_in, load_count_ff, load_count_in;
   logic             loading_ff, loading_in, active_ff, active_in;

   // result of the item in flight, waiting on ring read data
   logic [1:0]       p_status_ff, p_status_in;
   logic             p_shv_ff, p_shv_in, p_fwd_ff, p_fwd_in, p_rdv_ff, p_rdv_in;
   logic [7:0]       p_fwd_byte_ff, p_fwd_byte_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_shv_ff, rsp_shv_in, rsp_rdv_ff, rsp_rdv_in;
   logic [7:0]       rsp_shb_ff, rsp_shb_in, rsp_rdb_ff, rsp_rdb_in;
   logic             rsp_act_ff, rsp_act_in;

   logic             accept;
   logic [CNT_W-1:0] lc_eff;
   logic [PTR_W-1:0] th_eff, tt_eff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // a first load starts from cleared rings
   assign lc_eff = loading_ff ? load_count_ff : '0;
   assign th_eff = loading_ff ? tx_head_ff : '0;
   assign tt_eff = loading_ff ? tx_tail_ff : '0;

   always_comb begin
      state_in      = state_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      bytes_left_in = bytes_left_ff;
      load_count_in = load_count_ff;
      loading_in    = loading_ff;
      active_in     = active_ff;
      p_status_in   = p_status_ff;
      p_shv_in      = p_shv_ff;
      p_fwd_in      = p_fwd_ff;
      p_fwd_byte_in = p_fwd_byte_ff;
      p_rdv_in      = p_rdv_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_shv_in    = rsp_shv_ff;
      rsp_shb_in    = rsp_shb_ff;
      rsp_rdv_in    = rsp_rdv_ff;
      rsp_rdb_in    = rsp_rdb_ff;
      rsp_act_in    = rsp_act_ff;
      tx_req        = '0;
      rx_req        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         state_in      = S_RESULT;
         p_status_in   = STATUS_OK;
         p_shv_in      = 1'b0;
         p_fwd_in      = 1'b0;
         p_fwd_byte_in = req_tx_data;
         p_rdv_in      = 1'b0;
         unique case (req_type)
            REQ_LOAD: begin
               if (active_ff) begin
                  p_status_in = STATUS_BUSY;
               end else begin
                  if (!loading_ff) begin
                     tx_head_in    = '0;
                     tx_tail_in    = '0;
                     rx_head_in    = '0;
                     rx_tail_in    = '0;
                     load_count_in = '0;
                     loading_in    = 1'b1;
                  end
                  if (lc_eff == CNT_W'(RING_DEPTH)) begin
                     p_status_in = STATUS_SIZE;
                     if (req_last_load) begin
                        loading_in    = 1'b0;
                        load_count_in = '0;
                     end
                  end else begin
                     tx_req.wr_en   = 1'b1;
                     tx_req.wr_addr = th_eff;
                     tx_req.wr_data = req_tx_data;
                     tx_head_in     = ring_next(th_eff);
                     load_count_in  = lc_eff + CNT_W'(1);
                     if (req_last_load) begin
                        bytes_left_in = lc_eff;
                        p_shv_in      = 1'b1;
                        // single-byte transfer: the byte being written is the one shifted
                        p_fwd_in      = (lc_eff == '0);
                        tx_req.rd_en  = (lc_eff != '0);
                        tx_req.rd_addr = tt_eff;
                        tx_tail_in    = ring_next(tt_eff);
                        active_in     = 1'b1;
                        loading_in    = 1'b0;
                        load_count_in = '0;
                     end
                  end
               end
            end
            REQ_DONE: begin
               if (!active_ff) begin
                  p_status_in = STATUS_IGNORED;
               end else begin
                  // keep one slot free in the receive ring
                  if (ring_next(rx_head_ff) != rx_tail_ff) begin
                     rx_req.wr_en   = 1'b1;
                     rx_req.wr_addr = rx_head_ff;
                     rx_req.wr_data = req_rx_data;
                     rx_head_in     = ring_next(rx_head_ff);
                  end
                  if (bytes_left_ff != '0) begin
                     tx_req.rd_en   = 1'b1;
                     tx_req.rd_addr = tx_tail_ff;
                     tx_tail_in     = ring_next(tx_tail_ff);
                     bytes_left_in  = bytes_left_ff - CNT_W'(1);
                     p_shv_in       = 1'b1;
                  end else begin
                     active_in = 1'b0;
                  end
               end
            end
            REQ_READ: begin
               if (rx_head_ff != rx_tail_ff) begin
                  rx_req.rd_en   = 1'b1;
                  rx_req.rd_addr = rx_tail_ff;
                  rx_tail_in     = ring_next(rx_tail_ff);
                  p_rdv_in       = 1'b1;
               end
            end
            default: begin
               p_status_in = STATUS_IGNORED;
            end
         endcase
      end

      if (state_ff == S_RESULT && (!rsp_valid_ff || rsp_ready)) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = p_status_ff;
         rsp_shv_in    = p_shv_ff;
         rsp_shb_in    = !p_shv_ff ? 8'd0 : (p_fwd_ff ? p_fwd_byte_ff : tx_rd_data);
         rsp_rdv_in    = p_rdv_ff;
         rsp_rdb_in    = p_rdv_ff ? rx_rd_data : 8'd0;
         rsp_act_in    = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         bytes_left_ff <= '0;
         load_count_ff <= '0;
         loading_ff    <= 1'b0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         bytes_left_ff <= bytes_left_in;
         load_count_ff <= load_count_in;
         loading_ff    <= loading_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      p_status_ff   <= p_status_in;
      p_shv_ff      <= p_shv_in;
      p_fwd_ff      <= p_fwd_in;
      p_fwd_byte_ff <= p_fwd_byte_in;
      p_rdv_ff      <= p_rdv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_shv_ff    <= rsp_shv_in;
      rsp_shb_ff    <= rsp_shb_in;
      rsp_rdv_ff    <= rsp_rdv_in;
      rsp_rdb_ff    <= rsp_rdb_in;
      rsp_act_ff    <= rsp_act_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_shift_valid     = rsp_shv_ff;
   assign rsp_shift_byte      = rsp_shb_ff;
   assign rsp_read_valid      = rsp_rdv_ff;
   assign rsp_read_byte       = rsp_rdb_ff;
   assign rsp_transfer_active = rsp_act_ff;

endmodule
`default_nettype wire

>>> tb/tb_spi_buffered_transfer_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_buffered_transfer_engine_core
// self-checking bench for the buffered spi transfer engine: a directed table
// of corner cases, then random load/exchange/read sequences, every response
// compared field by field against the expected result that the table gives,
// else against a cycle-free model of the ring state
module tb_spi_buffered_transfer_engine_core;
   import spibte_pkg::*;

   localparam logic [1:0] REQ_SPARE   = 2'd3;
   localparam int         ITEM_TARGET = 700;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx;
      logic       last;
      logic [7:0] rx;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       shift_valid;
      logic [7:0] shift_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       active;
   } outcome_type;

   typedef struct {
      req_item_type req;
      bit           typed;
      outcome_type  want;
   } plan_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_type;
   logic [7:0] req_tx_data;
   logic       req_last_load;
   logic [7:0] req_rx_data;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_status;
   logic       rsp_shift_valid;
   logic [7:0] rsp_shift_byte;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_byte;
   logic       rsp_transfer_active;

   spi_buffered_transfer_engine_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_tx_data        (req_tx_data),
      .req_last_load      (req_last_load),
      .req_rx_data        (req_rx_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_shift_valid    (rsp_shift_valid),
      .rsp_shift_byte     (rsp_shift_byte),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_transfer_active(rsp_transfer_active)
   );

   // model state of the engine
   logic [7:0]       tx_bytes [RING_DEPTH];
   logic [7:0]       rx_bytes [RING_DEPTH];
   logic [PTR_W-1:0] tx_wr, tx_rd, rx_wr, rx_rd;
   logic [CNT_W-1:0] remaining, loaded;
   logic             filling, running;

   outcome_type  pending [$];
   plan_row_type plan_rows [$];
   int           err_count;
   int           useful_count;
   bit           calm;
   bit           quiet;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_spi_buffered_transfer_engine_core: errors");
      $finish;
   end

   function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
      return (int'(p) == RING_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic req_item_type mk_req(input logic [1:0] kind, input logic [7:0] tx,
                                           input logic last, input logic [7:0] rx);
      req_item_type r;
      r.kind = kind;
      r.tx   = tx;
      r.last = last;
      r.rx   = rx;
      return r;
   endfunction

   function automatic outcome_type mk_out(input logic [1:0] status, input logic sv,
                                          input logic [7:0] sb, input logic rv,
                                          input logic [7:0] rb, input logic act);
      outcome_type o;
      o.status      = status;
      o.shift_valid = sv;
      o.shift_byte  = sb;
      o.read_valid  = rv;
      o.read_byte   = rb;
      o.active      = act;
      return o;
   endfunction

   function automatic req_item_type random_req();
      return mk_req(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 8'($urandom));
   endfunction

   function automatic void plan(input req_item_type r, input bit typed,
                                input outcome_type want);
      plan_row_type row;
      row.req   = r;
      row.typed = typed;
      row.want  = want;
      plan_rows.push_back(row);
   endfunction

   // advances the ring state by one accepted transfer
   function automatic outcome_type predict_outcome(input req_item_type r);
      outcome_type o;
      o = '0;
      case (r.kind)
         REQ_LOAD: begin
            if (running) begin
               o.status = STATUS_BUSY;
            end else begin
               // opening load of a block empties both rings
               if (!filling) begin
                  tx_wr   = '0;
                  tx_rd   = '0;
                  rx_wr   = '0;
                  rx_rd   = '0;
                  loaded  = '0;
                  filling = 1'b1;
               end
               if (int'(loaded) >= RING_DEPTH) begin
                  o.status = STATUS_SIZE;
                  if (r.last) begin
                     filling = 1'b0;
                     loaded  = '0;
                  end
               end else begin
                  tx_bytes[tx_wr] = r.tx;
                  tx_wr           = step_ptr(tx_wr);
                  loaded          = loaded + 1'b1;
                  if (r.last) begin
                     o.shift_valid = 1'b1;
                     o.shift_byte  = tx_bytes[tx_rd];
                     tx_rd         = step_ptr(tx_rd);
                     remaining     = loaded - 1'b1;
                     running       = 1'b1;
                     filling       = 1'b0;
                     loaded        = '0;
                  end
               end
            end
         end
         REQ_DONE: begin
            if (!running) begin
               o.status = STATUS_IGNORED;
            end else begin
               // one slot always stays free, so the byte is lost when full
               if (step_ptr(rx_wr) != rx_rd) begin
                  rx_bytes[rx_wr] = r.rx;
                  rx_wr           = step_ptr(rx_wr);
               end
               if (remaining != '0) begin
                  o.shift_valid = 1'b1;
                  o.shift_byte  = tx_bytes[tx_rd];
                  tx_rd         = step_ptr(tx_rd);
                  remaining     = remaining - 1'b1;
               end else begin
                  running = 1'b0;
               end
            end
         end
         REQ_READ: begin
            if (rx_wr != rx_rd) begin
               o.read_valid = 1'b1;
               o.read_byte  = rx_bytes[rx_rd];
               rx_rd        = step_ptr(rx_rd);
            end
         end
         default: begin
            o.status = STATUS_IGNORED;
         end
      endcase
      o.active = running;
      return o;
   endfunction

   task automatic note_mismatch(input string field, input int got, input int want);
      if (err_count < 40) begin
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      end
      err_count++;
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_request(input req_item_type r, input bit typed,
                               input outcome_type want);
      outcome_type guess;
      int          gap;
      gap = 0;
      if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= r.kind;
      req_tx_data   <= r.tx;
      req_last_load <= r.last;
      req_rx_data   <= r.rx;
      do @(posedge clock); while (!req_ready);
      guess = predict_outcome(r);
      pending.push_back(typed ? want : guess);
      if (guess.status != STATUS_IGNORED) begin
         useful_count++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
   endtask

   // one block of loads, its exchanges and a few reads of what came back
   task automatic run_transfer();
      int n;
      int sel;
      bit close;
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
         n = $urandom_range(1, 4);
      end else if (sel < 16) begin
         n = $urandom_range(5, RING_DEPTH - 1);
      end else if (sel < 19) begin
         n = RING_DEPTH;
      end else begin
         n = $urandom_range(RING_DEPTH + 1, RING_DEPTH + 3);
      end
      // now and then leave the block open so the next one runs on from it
      close = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            push_request(random_req(), 1'b0, '0);
         end
         push_request(mk_req(REQ_LOAD, 8'($urandom), close && (i == n - 1), 8'($urandom)),
                      1'b0, '0);
      end
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 7);
         if (n < RING_DEPTH && sel == 0) begin
            push_request(mk_req(REQ_READ, 8'($urandom), 1'($urandom), 8'($urandom)), 1'b0, '0);
         end else if (sel == 1) begin
            push_request(mk_req(REQ_LOAD, 8'($urandom), 1'($urandom), 8'($urandom)), 1'b0, '0);
         end
         push_request(mk_req(REQ_DONE, 8'($urandom), 1'($urandom), 8'($urandom)), 1'b0, '0);
      end
      repeat ($urandom_range(0, n + 2)) begin
         push_request(mk_req(REQ_READ, 8'($urandom), 1'($urandom), 8'($urandom)), 1'b0, '0);
      end
   endtask

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset || quiet || calm || $urandom_range(0, 7) != 0) begin
            rsp_ready <= !reset;
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            note_mismatch("unexpected transfer, status", rsp_status, 0);
         end else begin
            want = pending.pop_front();
            if (rsp_status != want.status) begin
               note_mismatch("status", rsp_status, want.status);
            end
            if (rsp_shift_valid != want.shift_valid) begin
               note_mismatch("shift_valid", rsp_shift_valid, want.shift_valid);
            end
            if (rsp_shift_byte != want.shift_byte) begin
               note_mismatch("shift_byte", rsp_shift_byte, want.shift_byte);
            end
            if (rsp_read_valid != want.read_valid) begin
               note_mismatch("read_valid", rsp_read_valid, want.read_valid);
            end
            if (rsp_read_byte != want.read_byte) begin
               note_mismatch("read_byte", rsp_read_byte, want.read_byte);
            end
            if (rsp_transfer_active != want.active) begin
               note_mismatch("transfer_active", rsp_transfer_active, want.active);
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_LOAD;
      req_tx_data   = '0;
      req_last_load = 1'b0;
      req_rx_data   = '0;
      err_count     = 0;
      useful_count  = 0;
      calm          = 1'b0;
      quiet         = 1'b0;
      tx_wr         = '0;
      tx_rd         = '0;
      rx_wr         = '0;
      rx_rd         = '0;
      remaining     = '0;
      loaded        = '0;
      filling       = 1'b0;
      running       = 1'b0;

      // idle engine, empty reads and the unused request code
      plan(mk_req(REQ_DONE, 8'h00, 1'b0, 8'hFF), 1'b1,
           mk_out(STATUS_IGNORED, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0));
      plan(mk_req(REQ_READ, 8'hFF, 1'b1, 8'h00), 1'b1,
           mk_out(STATUS_OK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0));
      plan(mk_req(REQ_SPARE, 8'hFF, 1'b1, 8'hFF), 1'b1,
           mk_out(STATUS_IGNORED, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0));
      // two byte transfer with a load arriving while busy
      plan(mk_req(REQ_LOAD, 8'h00, 1'b0, 8'h00), 1'b0, '0);
      plan(mk_req(REQ_LOAD, 8'hFF, 1'b1, 8'h00), 1'b0, '0);
      plan(mk_req(REQ_LOAD, 8'h5A, 1'b1, 8'hA5), 1'b1,
           mk_out(STATUS_BUSY, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1));
      plan(mk_req(REQ_DONE, 8'h00, 1'b0, 8'hFF), 1'b0, '0);
      plan(mk_req(REQ_DONE, 8'hFF, 1'b1, 8'h00), 1'b0, '0);
      plan(mk_req(REQ_READ, 8'h00, 1'b0, 8'h00), 1'b1,
           mk_out(STATUS_OK, 1'b0, 8'h00, 1'b1, 8'hFF, 1'b0));
      // fill the ring, then overflow with the closing load
      for (int i = 0; i < RING_DEPTH; i++) begin
         plan(mk_req(REQ_LOAD, 8'(i * 17), 1'b0, 8'h00), 1'b0, '0);
      end
      plan(mk_req(REQ_LOAD, 8'hA5, 1'b1, 8'h5A), 1'b1,
           mk_out(STATUS_SIZE, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0));
      plan(mk_req(REQ_READ, 8'h00, 1'b0, 8'h00), 1'b1,
           mk_out(STATUS_OK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan_rows[i]) begin
         push_request(plan_rows[i].req, plan_rows[i].typed, plan_rows[i].want);
      end
      wait_drained();

      useful_count = 0;
      while (useful_count < ITEM_TARGET) begin
         calm  = ($urandom_range(0, 4) == 0);
         quiet = (useful_count > ITEM_TARGET - 80);
         if ($urandom_range(0, 99) < 75) begin
            run_transfer();
         end else begin
            repeat ($urandom_range(1, 4)) push_request(random_req(), 1'b0, '0);
         end
         if ($urandom_range(0, 24) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (err_count == 0) begin
         $display("tb_spi_buffered_transfer_engine_core: clean");
      end else begin
         $display("tb_spi_buffered_transfer_engine_core: errors");
      end
      $finish;
   end

endmodule
